// File: rtl/relief_convolution_3x3_top_defines.svh
// assertion macros for the relief convolution block
// used by relief_convolution_3x3_top; expects clk and rst_n in scope
`ifndef RELIEF_CONVOLUTION_3X3_TOP_DEFINES_SVH
`define RELIEF_CONVOLUTION_3X3_TOP_DEFINES_SVH

// same-cycle implication
`define RCV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rcv_pkg.sv
// shared types and constants for the relief convolution block
// no dependencies
`default_nettype none
package rcv_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int PIX_W       = 8;
  localparam int WIDTH_W     = 13;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_W       = 16;
  localparam int SUM_W       = 11;
  localparam int RECIP_W     = 10;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 13'd3;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = 13'd4096;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 16'd3;

  // kernel offset and divide-by-6 as multiply by 683 / 4096 (exact below 2048)
  localparam logic [SUM_W-1:0]   KERNEL_OFFSET = 11'd765;
  localparam logic [RECIP_W-1:0] DIV6_RECIP    = 10'd683;
  localparam int                 DIV6_SHIFT    = 12;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  // one item sitting in the input stage
  typedef struct packed {
    logic             pix;       // pixel: shift window, write line buffers
    logic             emit;      // gives at least one result
    logic             interior;  // first result is a kernel value
    logic             extra;     // row end: trailing border zero follows
    logic             fend;      // final output of the frame
    logic [PIX_W-1:0] px;
    logic [COL_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
    logic             fend;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/rcv_line_ram.sv
// simple dual-port line buffer memory, registered read
// no dependencies
`default_nettype none
module rcv_line_ram #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/rcv_ctrl.sv
// config registers, raster counters and the input stage register
// depends on rcv_pkg
`default_nettype none
module rcv_ctrl
  import rcv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                in_tvalid,
  output      logic                in_tready,
  input  wire logic [PIX_W-1:0]    in_pixel,
  input  wire logic                in_drain,
  input  wire logic                a_go,
  output      logic                a_valid,
  output      item_t               a_item,
  output      logic                rd_en,
  output      logic [COL_W-1:0]    rd_addr
);

  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0]    drn_r, drn_nxt;
  logic                a_valid_r, a_valid_nxt;
  item_t               a_item_r, a_item_nxt;

  logic [WIDTH_W-1:0]  w_eff;
  logic [COL_W-1:0]    w_last;
  logic [HEIGHT_W-1:0] h_eff;
  logic                in_drain_phase;
  logic                in_fire;
  logic                take_pix;
  logic                take_drn;

  always_comb begin
    if (width_r < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (width_r > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r < HEIGHT_MIN) ? HEIGHT_MIN : height_r;
  end

  assign w_last         = COL_W'(w_eff - 13'd1);
  assign in_drain_phase = (row_r == h_eff);
  assign in_tready      = !a_valid_r || a_go;
  assign in_fire        = in_tvalid && in_tready;
  // items that give nothing are taken and dropped here
  assign take_pix       = in_fire && !in_drain && !in_drain_phase;
  assign take_drn       = in_fire && in_drain && in_drain_phase;
  assign rd_en          = take_pix;
  assign rd_addr        = col_r;
  assign a_valid        = a_valid_r;
  assign a_item         = a_item_r;

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    drn_nxt     = drn_r;
    a_item_nxt  = a_item_r;
    a_valid_nxt = a_valid_r;

    if (in_fire) begin
      a_valid_nxt = take_pix || take_drn;
    end else if (a_go) begin
      a_valid_nxt = 1'b0;
    end

    if (take_pix) begin
      a_item_nxt.pix      = 1'b1;
      a_item_nxt.emit     = (row_r != '0) && (col_r != '0);
      a_item_nxt.interior = (row_r >= 16'd2) && (col_r >= 12'd2);
      a_item_nxt.extra    = (col_r == w_last);
      a_item_nxt.fend     = 1'b0;
      a_item_nxt.px       = in_pixel;
      a_item_nxt.col      = col_r;
      if (col_r == w_last) begin
        col_nxt = '0;
        row_nxt = row_r + 16'd1;
      end else begin
        col_nxt = col_r + 12'd1;
      end
    end else if (take_drn) begin
      a_item_nxt.pix      = 1'b0;
      a_item_nxt.emit     = 1'b1;
      a_item_nxt.interior = 1'b0;
      a_item_nxt.extra    = 1'b0;
      a_item_nxt.fend     = (drn_r == w_last);
      a_item_nxt.px       = in_pixel;
      a_item_nxt.col      = col_r;
      if (drn_r == w_last) begin
        col_nxt = '0;
        row_nxt = '0;
        drn_nxt = '0;
      end else begin
        drn_nxt = drn_r + 12'd1;
      end
    end

    // any register write restarts the frame
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_wdata[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_nxt = cfg_wdata[HEIGHT_W-1:0];
        default:          width_nxt  = width_r;
      endcase
      col_nxt = '0;
      row_nxt = '0;
      drn_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      col_r     <= '0;
      row_r     <= '0;
      drn_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      drn_r     <= drn_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r <= a_item_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/rcv_kernel.sv
// 3x3 window registers and the emboss arithmetic
// depends on rcv_pkg
`default_nettype none
module rcv_kernel
  import rcv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             upd,
  input  wire item_t            a_item,
  input  wire logic [PIX_W-1:0] rd_older,
  input  wire logic [PIX_W-1:0] rd_newer,
  output      logic [PIX_W-1:0] value
);

  // only the taps needed for the next shift are kept:
  // top row cols 1,2, middle row cols 1,2, bottom row col 2
  logic [PIX_W-1:0]  win1_r, win2_r, win4_r, win5_r, win8_r;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (upd) begin
      win1_r <= win2_r;
      win2_r <= rd_older;
      win4_r <= win5_r;
      win5_r <= rd_newer;
      win8_r <= a_item.px;
    end
  end

  // after the shift: nw=win1, n=win2, w=win4, e=rd_newer, s=win8, se=px
  // offset keeps the sum non-negative, max 1530
  assign sum = KERNEL_OFFSET
             + SUM_W'(rd_newer) + SUM_W'(win8_r) + SUM_W'(a_item.px)
             - SUM_W'(win1_r) - SUM_W'(win2_r) - SUM_W'(win4_r);

  assign prod = PROD_W'(sum) * PROD_W'(DIV6_RECIP);

  // quotient never exceeds 255, so no upper clamp is needed
  assign value = a_item.interior ? PIX_W'(prod >> DIV6_SHIFT) : '0;

endmodule
`default_nettype wire

// File: rtl/rcv_outbuf.sv
// output register with one pending slot for the row-end border zero
// depends on rcv_pkg
`default_nettype none
module rcv_outbuf
  import rcv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire res_t             first,
  input  wire logic             second,
  output      logic             room,
  output      logic             pend,
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  output      logic [PIX_W-1:0] out_value,
  output      logic             out_last,
  output      logic             out_fend
);

  logic out_valid_r, out_valid_nxt;
  logic pend_r, pend_nxt;
  res_t res_r, res_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign room      = slot_free && !pend_r;
  assign pend      = pend_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    if (slot_free) begin
      if (pend_r) begin
        res_nxt       = '{value: '0, last: 1'b1, fend: 1'b0};
        out_valid_nxt = 1'b1;
        pend_nxt      = 1'b0;
      end else if (push) begin
        res_nxt       = first;
        out_valid_nxt = 1'b1;
        pend_nxt      = second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = res_r.value;
  assign out_last   = res_r.last;
  assign out_fend   = res_r.fend;

endmodule
`default_nettype wire

// File: rtl/relief_convolution_3x3_top.sv
// top level of the 3x3 relief (emboss) filter
// depends on rcv_pkg, rcv_ctrl, rcv_line_ram, rcv_kernel, rcv_outbuf and the defines header
//
//  port group | direction | contents
//  in_*       | in        | tdata[7:0] pixel, tuser drain
//  out_*      | out       | tdata[7:0] value, tlast run_last, tuser frame_end
//  cfg_*      | in        | index 0 image_width, index 1 image_height
//
// one item per clock unless stalled: an item sits in the input stage register while
// the line buffers are read, and its result goes into the output register as it leaves
// a row-end item gives two results; the item after it waits for the trailing zero
// only when it gives a result of its own
// a stalled output holds the input stage; no clearing pass after reset
// reset returns to 640 x 480 at the start of a frame
`default_nettype none
`include "relief_convolution_3x3_top_defines.svh"
module relief_convolution_3x3_top
  import rcv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output      logic             in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] pixel
  input  wire logic             in_tuser,   // [0] drain
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  output      logic [7:0]       out_tdata,  // [7:0] value
  output      logic             out_tlast,
  output      logic             out_tuser,  // [0] frame_end
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic             a_valid;
  item_t            a_item;
  logic             a_go;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  logic [PIX_W-1:0] rd_older;
  logic [PIX_W-1:0] rd_newer;
  logic [PIX_W-1:0] kval;
  logic             room;
  logic             pend;
  logic             wr_en;
  res_t             first;

  // items with no result never wait for the output side
  assign a_go  = a_valid && (!a_item.emit || room);
  assign wr_en = a_go && a_item.pix;
  assign first = '{value: kval, last: !a_item.extra, fend: a_item.fend};

  rcv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pixel  (in_tdata),
    .in_drain  (in_tuser),
    .a_go      (a_go),
    .a_valid   (a_valid),
    .a_item    (a_item),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // older line takes what the newer line held at this column
  rcv_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W)) u_older (
    .clk   (clk),
    .we    (wr_en),
    .waddr (a_item.col),
    .wdata (rd_newer),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_older)
  );

  rcv_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W)) u_newer (
    .clk   (clk),
    .we    (wr_en),
    .waddr (a_item.col),
    .wdata (a_item.px),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_newer)
  );

  rcv_kernel u_kernel (
    .clk      (clk),
    .upd      (wr_en),
    .a_item   (a_item),
    .rd_older (rd_older),
    .rd_newer (rd_newer),
    .value    (kval)
  );

  rcv_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (a_go && a_item.emit),
    .first      (first),
    .second     (a_item.extra),
    .room       (room),
    .pend       (pend),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_tdata),
    .out_last   (out_tlast),
    .out_fend   (out_tuser)
  );

  `RCV_ASSERT_NOW(a_pend_has_out, pend, out_tvalid, "pending zero without a shown result")
  `RCV_ASSERT_NEXT(a_row_end_pend, a_go && a_item.emit && a_item.extra, pend,
    "row-end transaction did not leave its trailing zero pending")
  `RCV_ASSERT_NOW(a_fend_zero, out_tvalid && out_tuser, out_tdata == '0 && out_tlast,
    "frame end result is not a final border zero")
  `RCV_ASSERT_NOW(a_stall_cause, !in_tready, a_valid && !a_go,
    "input stalled with a free input stage")

endmodule
`default_nettype wire
